>>> sv/tpc_pkg.sv
// Shared types and constants for the triangle plane clipper.
package tpc_pkg;

   localparam int COORD_W = 32;            // vertex coordinate, Q16.16
   localparam int DIFF_W  = COORD_W + 1;   // vertex minus plane point, edge delta
   localparam int PROD_W  = COORD_W + DIFF_W;
   localparam int DIST_W  = PROD_W + 2;    // sum of three products
   localparam int DEN_W   = DIST_W + 1;    // d(in) - d(out)
   localparam int T_W     = 32;            // crossing fraction bits
   localparam int MUL_W   = DIFF_W + T_W + 1;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [2:0] REG_POINT_X  = 3'd0;
   localparam logic [2:0] REG_POINT_Y  = 3'd1;
   localparam logic [2:0] REG_POINT_Z  = 3'd2;
   localparam logic [2:0] REG_NORMAL_X = 3'd3;
   localparam logic [2:0] REG_NORMAL_Y = 3'd4;
   localparam logic [2:0] REG_NORMAL_Z = 3'd5;

   localparam logic [COORD_W-1:0] POINT_Z_RESET  = COORD_W'(6554);
   localparam logic [COORD_W-1:0] NORMAL_Z_RESET = COORD_W'(65536);

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
   } tpc_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out0_x;
      logic signed [COORD_W-1:0] out0_y;
      logic signed [COORD_W-1:0] out0_z;
      logic signed [COORD_W-1:0] out1_x;
      logic signed [COORD_W-1:0] out1_y;
      logic signed [COORD_W-1:0] out1_z;
      logic signed [COORD_W-1:0] out2_x;
      logic signed [COORD_W-1:0] out2_y;
      logic signed [COORD_W-1:0] out2_z;
      logic                      last_triangle;
   } tpc_rsp_type;

   typedef enum logic [1:0] {
      CASE_PASS,
      CASE_ONE,
      CASE_TWO
   } tpc_case_type;

   // What travels alongside the two divisions.
   typedef struct packed {
      tpc_case_type                  kind;
      logic [2:0][COORD_W-1:0]       pa;
      logic [2:0][COORD_W-1:0]       pb;
      logic [2:0][COORD_W-1:0]       pc;
      logic [1:0][2:0][DIFF_W-1:0]   dlt;
   } tpc_carry_type;

endpackage

>>> sv/tpc_divider.sv
// Two pipelined restoring dividers, one quotient bit per stage.
module tpc_divider (
   input  logic                              clock,
   input  logic                              en,
   input  logic [1:0][tpc_pkg::DEN_W-1:0]    num,
   input  logic [1:0][tpc_pkg::DEN_W-1:0]    den,
   output logic [1:0][tpc_pkg::T_W-1:0]      quo
);
   import tpc_pkg::*;

   logic [DEN_W-1:0] rem_ff [2][T_W];
   logic [DEN_W-1:0] den_ff [2][T_W];
   logic [T_W-1:0]   quo_ff [2][T_W];
   logic [DEN_W-1:0] rem_in [2][T_W];
   logic [T_W-1:0]   quo_in [2][T_W];

   always_comb begin
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [T_W-1:0]   quo_prev;
      logic [DEN_W:0]   shifted;
      logic [DEN_W:0]   trial;
      for (int l = 0; l < 2; l++) begin
         for (int k = 0; k < T_W; k++) begin
            if (k == 0) begin
               rem_prev = num[l];
               den_prev = den[l];
               quo_prev = '0;
            end else begin
               rem_prev = rem_ff[l][k-1];
               den_prev = den_ff[l][k-1];
               quo_prev = quo_ff[l][k-1];
            end
            shifted = {rem_prev, 1'b0};
            trial   = shifted - {1'b0, den_prev};
            // keep the remainder below the divisor, shift in the quotient bit
            rem_in[l][k] = trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_in[l][k] = {quo_prev[T_W-2:0], ~trial[DEN_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < T_W; k++) begin
               rem_ff[l][k] <= rem_in[l][k];
               quo_ff[l][k] <= quo_in[l][k];
               den_ff[l][k] <= (k == 0) ? den[l] : den_ff[l][k-1];
            end
         end
      end
   end

   assign quo[0] = quo_ff[0][T_W-1];
   assign quo[1] = quo_ff[1][T_W-1];

endmodule

>>> sv/triangle_plane_clipper.sv
// Triangle clipper against one configurable plane, pipelined, top level.
//
// Usage: a request carries one triangle of three Q16.16 vertices on req_*
// (valid/ready). Each request yields zero, one or two result triangles on
// rsp_* (valid/ready); last_triangle marks the final one of a request.
// Requests that fall fully outside the plane, or arrive while the normal is
// zero, produce nothing. The plane point and inward normal sit in six
// 32-bit registers on an APB-style port (byte address 4*i); write them only
// while no request is in flight.
// Pipeline: the accepting edge loads the first of 38 registers: three for
// the distance, one for classification, 32 for the bit-serial crossing
// division, one for the crossing multiply and one for the output holding
// register, which drives rsp_valid.
// Throughput: one request per cycle while each yields at most one result
// and rsp_ready is high; a request with two results stalls until both are taken.
// When the receiver stalls, the whole pipeline holds in place and req_ready
// drops; nothing is lost or repeated. Synchronous reset clears all valid
// bits and loads the plane registers with point (0, 0, 0.1) and normal
// (0, 0, 1).
module triangle_plane_clipper (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tpc_pkg::tpc_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tpc_pkg::tpc_rsp_type         rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tpc_pkg::CSR_AW-1:0]   paddr,
   input  logic [tpc_pkg::CSR_DW-1:0]   pwdata,
   output logic [tpc_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import tpc_pkg::*;

   // ---------------------------------------------------------------- config
   logic [2:0][COORD_W-1:0] point_ff, point_in;
   logic [2:0][COORD_W-1:0] normal_ff, normal_in;
   logic                    csr_wr;
   logic [2:0]              csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_AW-1:2];

   always_comb begin
      point_in  = point_ff;
      normal_in = normal_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_POINT_X:  point_in[0]  = pwdata;
            REG_POINT_Y:  point_in[1]  = pwdata;
            REG_POINT_Z:  point_in[2]  = pwdata;
            REG_NORMAL_X: normal_in[0] = pwdata;
            REG_NORMAL_Y: normal_in[1] = pwdata;
            REG_NORMAL_Z: normal_in[2] = pwdata;
            default: ;    // write beyond the register list: ignore
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff  <= {POINT_Z_RESET, {COORD_W{1'b0}}, {COORD_W{1'b0}}};
         normal_ff <= {NORMAL_Z_RESET, {COORD_W{1'b0}}, {COORD_W{1'b0}}};
      end else begin
         point_ff  <= point_in;
         normal_ff <= normal_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_POINT_X:  prdata = point_ff[0];
         REG_POINT_Y:  prdata = point_ff[1];
         REG_POINT_Z:  prdata = point_ff[2];
         REG_NORMAL_X: prdata = normal_ff[0];
         REG_NORMAL_Y: prdata = normal_ff[1];
         REG_NORMAL_Z: prdata = normal_ff[2];
         default:      prdata = '0;
      endcase
   end

   // ------------------------------------------------------- global advance
   // One enable moves every stage; it drops only when the output holder is
   // full and will not empty this cycle.
   logic adv;
   logic hv_ff;
   logic phase_ff;
   tpc_carry_type h_ff;
   logic last_now;

   assign last_now  = (h_ff.kind != CASE_TWO) || phase_ff;
   assign adv       = !hv_ff || (rsp_ready && last_now);
   assign req_ready = adv;

   // ------------------------------------------- stage 1: vertex - plane point
   logic [2:0][2:0][COORD_W-1:0] req_vtx;
   logic [2:0][2:0][COORD_W-1:0] s1_vtx_ff, s2_vtx_ff, s3_vtx_ff;
   logic [2:0][2:0][DIFF_W-1:0]  s1_diff_ff, s1_diff_in;
   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;

   assign req_vtx[0][0] = req_data.v0_x;
   assign req_vtx[0][1] = req_data.v0_y;
   assign req_vtx[0][2] = req_data.v0_z;
   assign req_vtx[1][0] = req_data.v1_x;
   assign req_vtx[1][1] = req_data.v1_y;
   assign req_vtx[1][2] = req_data.v1_z;
   assign req_vtx[2][0] = req_data.v2_x;
   assign req_vtx[2][1] = req_data.v2_y;
   assign req_vtx[2][2] = req_data.v2_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_diff_in[i][j] = DIFF_W'($signed(req_vtx[i][j]))
                             - DIFF_W'($signed(point_ff[j]));
         end
      end
   end

   // --------------------------------------------- stage 2: normal products
   logic [2:0][2:0][PROD_W-1:0] s2_prod_ff, s2_prod_in;

   always_comb begin
      logic signed [PROD_W-1:0] opn;
      logic signed [PROD_W-1:0] opd;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            opn = PROD_W'($signed(normal_ff[j]));
            opd = PROD_W'($signed(s1_diff_ff[i][j]));
            s2_prod_in[i][j] = opn * opd;
         end
      end
   end

   // ------------------------------------------------ stage 3: distance sum
   logic [2:0][DIST_W-1:0] s3_dist_ff, s3_dist_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_dist_in[i] = DIST_W'($signed(s2_prod_ff[i][0]))
                       + DIST_W'($signed(s2_prod_ff[i][1]))
                       + DIST_W'($signed(s2_prod_ff[i][2]));
      end
   end

   // ----------------------------------------------- stage 4: classification
   logic [2:0]             in_mask;
   logic                   zero_normal;
   logic                   c_drop;
   tpc_case_type           c_kind;
   logic [1:0]             ia, ib, oa, ob;
   tpc_carry_type          c_carry_in, c_carry_ff;
   logic [1:0][DEN_W-1:0]  c_num_in, c_num_ff, c_den_in, c_den_ff;
   logic                   c_valid_ff;

   assign zero_normal = (normal_ff == '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_mask[i] = ~s3_dist_ff[i][DIST_W-1];
      end
   end

   // Pick the inside/outside endpoints of the two crossing edges.
   always_comb begin
      c_drop = 1'b0;
      c_kind = CASE_PASS;
      ia = 2'd0;
      ib = 2'd1;
      oa = 2'd0;
      ob = 2'd0;
      case (in_mask)
         3'b000: c_drop = 1'b1;
         3'b111: c_kind = CASE_PASS;
         3'b001: begin c_kind = CASE_ONE; ia = 2'd0; ib = 2'd0; oa = 2'd1; ob = 2'd2; end
         3'b010: begin c_kind = CASE_ONE; ia = 2'd1; ib = 2'd1; oa = 2'd0; ob = 2'd2; end
         3'b100: begin c_kind = CASE_ONE; ia = 2'd2; ib = 2'd2; oa = 2'd0; ob = 2'd1; end
         3'b011: begin c_kind = CASE_TWO; ia = 2'd0; ib = 2'd1; oa = 2'd2; ob = 2'd2; end
         3'b101: begin c_kind = CASE_TWO; ia = 2'd0; ib = 2'd2; oa = 2'd1; ob = 2'd1; end
         3'b110: begin c_kind = CASE_TWO; ia = 2'd1; ib = 2'd2; oa = 2'd0; ob = 2'd0; end
         default: c_drop = 1'b1;
      endcase
   end

   always_comb begin
      c_carry_in.kind = c_kind;
      c_carry_in.pa   = s3_vtx_ff[ia];
      c_carry_in.pb   = s3_vtx_ff[ib];
      c_carry_in.pc   = s3_vtx_ff[2];
      for (int j = 0; j < 3; j++) begin
         c_carry_in.dlt[0][j] = DIFF_W'($signed(s3_vtx_ff[oa][j]))
                              - DIFF_W'($signed(s3_vtx_ff[ia][j]));
         c_carry_in.dlt[1][j] = DIFF_W'($signed(s3_vtx_ff[ob][j]))
                              - DIFF_W'($signed(s3_vtx_ff[ib][j]));
      end
      // numerator is d(inside) >= 0, divisor d(inside) - d(outside) > 0
      c_num_in[0] = {1'b0, s3_dist_ff[ia]};
      c_num_in[1] = {1'b0, s3_dist_ff[ib]};
      c_den_in[0] = DEN_W'($signed(s3_dist_ff[ia])) - DEN_W'($signed(s3_dist_ff[oa]));
      c_den_in[1] = DEN_W'($signed(s3_dist_ff[ib])) - DEN_W'($signed(s3_dist_ff[ob]));
   end

   // ------------------------------------------- front pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         c_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         // drop triangles fully outside, or any triangle under a zero normal
         c_valid_ff  <= s3_valid_ff && !c_drop && !zero_normal;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_vtx_ff  <= req_vtx;
         s1_diff_ff <= s1_diff_in;
         s2_vtx_ff  <= s1_vtx_ff;
         s2_prod_ff <= s2_prod_in;
         s3_vtx_ff  <= s2_vtx_ff;
         s3_dist_ff <= s3_dist_in;
         c_carry_ff <= c_carry_in;
         c_num_ff   <= c_num_in;
         c_den_ff   <= c_den_in;
      end
   end

   // ------------------------------------------------ crossing division
   logic [1:0][T_W-1:0] quo;
   logic                dv_ff [T_W];
   tpc_carry_type       dc_ff [T_W];

   tpc_divider u_div (
      .clock (clock),
      .en    (adv),
      .num   (c_num_ff),
      .den   (c_den_ff),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < T_W; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < T_W; k++) begin
            dv_ff[k] <= (k == 0) ? c_valid_ff : dv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < T_W; k++) begin
            dc_ff[k] <= (k == 0) ? c_carry_ff : dc_ff[k-1];
         end
      end
   end

   // ------------------------------------------ crossing multiply (delta * t)
   logic                          m_valid_ff;
   tpc_carry_type                 m_carry_ff;
   logic [1:0][2:0][MUL_W-1:0]    m_prod_ff, m_prod_in;

   always_comb begin
      logic signed [MUL_W-1:0] opa;
      logic signed [MUL_W-1:0] opt;
      for (int l = 0; l < 2; l++) begin
         for (int j = 0; j < 3; j++) begin
            opa = MUL_W'($signed(dc_ff[T_W-1].dlt[l][j]));
            opt = $signed({{(MUL_W-T_W){1'b0}}, quo[l]});
            m_prod_in[l][j] = opa * opt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= dv_ff[T_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_carry_ff <= dc_ff[T_W-1];
         m_prod_ff  <= m_prod_in;
      end
   end

   // -------------------------------------------------- output holder
   // Crossing = inside vertex + floor(delta * t / 2^32), kept in range.
   logic [1:0][2:0][COORD_W-1:0] x_in, x_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         x_in[0][j] = m_carry_ff.pa[j] + m_prod_ff[0][j][T_W+COORD_W-1:T_W];
         x_in[1][j] = m_carry_ff.pb[j] + m_prod_ff[1][j][T_W+COORD_W-1:T_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff    <= 1'b0;
         phase_ff <= 1'b0;
      end else if (adv) begin
         hv_ff    <= m_valid_ff;
         phase_ff <= 1'b0;
      end else if (rsp_ready) begin
         // first of two triangles taken: advance to the second
         phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff <= m_carry_ff;
         x_ff <= x_in;
      end
   end

   logic [2:0][2:0][COORD_W-1:0] otri;

   always_comb begin
      unique case (h_ff.kind)
         CASE_PASS: otri = {h_ff.pc, h_ff.pb, h_ff.pa};
         CASE_ONE:  otri = {x_ff[1], x_ff[0], h_ff.pa};
         CASE_TWO:  otri = phase_ff ? {x_ff[1], x_ff[0], h_ff.pb}
                                    : {x_ff[0], h_ff.pb, h_ff.pa};
         default:   otri = {h_ff.pc, h_ff.pb, h_ff.pa};
      endcase
   end

   assign rsp_valid              = hv_ff;
   assign rsp_data.out0_x        = otri[0][0];
   assign rsp_data.out0_y        = otri[0][1];
   assign rsp_data.out0_z        = otri[0][2];
   assign rsp_data.out1_x        = otri[1][0];
   assign rsp_data.out1_y        = otri[1][1];
   assign rsp_data.out1_z        = otri[1][2];
   assign rsp_data.out2_x        = otri[2][0];
   assign rsp_data.out2_y        = otri[2][1];
   assign rsp_data.out2_z        = otri[2][2];
   assign rsp_data.last_triangle = last_now;

endmodule

>>> sv/tpc_checker.sv
// Port-level assertions for the triangle plane clipper, bound to the top.
module tpc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input tpc_pkg::tpc_req_type         req_data,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input tpc_pkg::tpc_rsp_type         rsp_data,
   input logic                         psel,
   input logic                         penable,
   input logic                         pwrite,
   input logic [tpc_pkg::CSR_AW-1:0]   paddr,
   input logic [tpc_pkg::CSR_DW-1:0]   pwdata,
   input logic [tpc_pkg::CSR_DW-1:0]   prdata,
   input logic                         pready
);
   import tpc_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a non-final triangle is always followed by its partner
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_triangle |=> rsp_valid)
      else $error("second triangle of a pair missing");

   // with the output empty the block must take requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while output empty");

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the triangle plane clipper: random and directed triangles.
`timescale 1ns / 1ps

module tb;
   import tpc_pkg::*;

   localparam int TOTAL_RANDOM = 1300;
   localparam int DRAIN_CYCLES = 60;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   tpc_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   tpc_rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   triangle_plane_clipper uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Local copy of the plane registers: points then normal.
   logic signed [COORD_W-1:0] plane_pt [3];
   logic signed [COORD_W-1:0] plane_nrm [3];

   tpc_req_type pending_tris [$];
   tpc_rsp_type expected_tris [$];
   int errors;
   int accepted;
   int produced;
   int clipped_one, clipped_two, passed_whole, culled;

   // Signed distance of a vertex, exact at full width.
   function automatic logic signed [127:0] plane_dist(logic signed [COORD_W-1:0] vx,
         logic signed [COORD_W-1:0] vy, logic signed [COORD_W-1:0] vz);
      logic signed [127:0] s;
      s = 128'(plane_nrm[0]) * (128'(vx) - 128'(plane_pt[0]))
        + 128'(plane_nrm[1]) * (128'(vy) - 128'(plane_pt[1]))
        + 128'(plane_nrm[2]) * (128'(vz) - 128'(plane_pt[2]));
      return s;
   endfunction

   // Edge crossing from inside vertex a to outside vertex b.
   function automatic logic [3*COORD_W-1:0] edge_cross(logic [3*COORD_W-1:0] a,
         logic signed [127:0] da, logic [3*COORD_W-1:0] b, logic signed [127:0] db);
      logic [127:0] den;
      logic [127:0] frac;
      logic signed [127:0] prod;
      logic signed [COORD_W-1:0] ca, cb;
      logic [3*COORD_W-1:0] res;
      den = da - db;
      frac = (da <<< 32) / den;
      for (int k = 0; k < 3; k++) begin
         ca = a[(2-k)*COORD_W +: COORD_W];
         cb = b[(2-k)*COORD_W +: COORD_W];
         prod = (128'(cb) - 128'(ca)) * $signed({1'b0, frac[126:0]});
         res[(2-k)*COORD_W +: COORD_W] = ca + COORD_W'(prod >>> 32);
      end
      return res;
   endfunction

   function automatic tpc_rsp_type make_tri(logic [3*COORD_W-1:0] p0,
         logic [3*COORD_W-1:0] p1, logic [3*COORD_W-1:0] p2, logic last);
      return {p0, p1, p2, last};
   endfunction

   // Push the triangles a request should produce.
   task automatic predict_clip(tpc_req_type t);
      logic [3*COORD_W-1:0] v [3];
      logic signed [127:0] d [3];
      int ins [$];
      int outs [$];
      logic [3*COORD_W-1:0] x0, x1;
      v[0] = {t.v0_x, t.v0_y, t.v0_z};
      v[1] = {t.v1_x, t.v1_y, t.v1_z};
      v[2] = {t.v2_x, t.v2_y, t.v2_z};
      if (plane_nrm[0] == 0 && plane_nrm[1] == 0 && plane_nrm[2] == 0) begin
         culled++;
         return;
      end
      for (int i = 0; i < 3; i++) begin
         d[i] = plane_dist(v[i][3*COORD_W-1 -: COORD_W], v[i][2*COORD_W-1 -: COORD_W],
                           v[i][COORD_W-1:0]);
         if (d[i] < 0) outs.push_back(i);
         else ins.push_back(i);
      end
      case (ins.size())
         0: culled++;
         3: begin
            expected_tris.push_back(make_tri(v[0], v[1], v[2], 1'b1));
            passed_whole++;
         end
         1: begin
            x0 = edge_cross(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]]);
            x1 = edge_cross(v[ins[0]], d[ins[0]], v[outs[1]], d[outs[1]]);
            expected_tris.push_back(make_tri(v[ins[0]], x0, x1, 1'b1));
            clipped_one++;
         end
         default: begin
            x0 = edge_cross(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]]);
            x1 = edge_cross(v[ins[1]], d[ins[1]], v[outs[0]], d[outs[0]]);
            expected_tris.push_back(make_tri(v[ins[0]], v[ins[1]], x0, 1'b0));
            expected_tris.push_back(make_tri(v[ins[1]], x0, x1, 1'b1));
            clipped_two++;
         end
      endcase
   endtask

   // Request driver: hold the payload until accepted, then wait a random gap;
   // a zero gap presents the next request right away.
   int req_gap;
   int req_draw;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && req_ready) begin
         predict_clip(req_data);
         accepted++;
         void'(pending_tris.pop_front());
         if ($urandom_range(0, 3) == 0) req_draw = 0;
         else req_draw = $urandom_range(0, 16);
         if (req_draw == 0 && pending_tris.size() > 0) begin
            req_data <= pending_tris[0];
         end else begin
            req_valid <= 1'b0;
            req_gap <= (req_draw > 0) ? req_draw - 1 : 0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_tris.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_tris[0];
         end
      end
   end

   // Result monitor with random backpressure; a zero wait keeps ready high.
   int rsp_hold;
   int rsp_draw;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            produced++;
            if (expected_tris.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_tris[0]) begin
                  $display("%0t: mismatch expected %h actual %h", $time,
                           expected_tris[0], rsp_data);
                  errors++;
               end
               void'(expected_tris.pop_front());
            end
            rsp_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (rsp_draw > 0) begin
               rsp_hold <= rsp_draw - 1;
               rsp_ready <= 1'b0;
            end
         end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Register write: setup then access phase, at idle only.
   task automatic csr_write(logic [2:0] idx, logic signed [COORD_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_AW'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx <= REG_POINT_Z) plane_pt[idx] = val;
      else plane_nrm[idx - REG_NORMAL_X] = val;
   endtask

   task automatic set_plane(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
         logic signed [COORD_W-1:0] pz, logic signed [COORD_W-1:0] nx,
         logic signed [COORD_W-1:0] ny, logic signed [COORD_W-1:0] nz);
      csr_write(REG_POINT_X, px);
      csr_write(REG_POINT_Y, py);
      csr_write(REG_POINT_Z, pz);
      csr_write(REG_NORMAL_X, nx);
      csr_write(REG_NORMAL_Y, ny);
      csr_write(REG_NORMAL_Z, nz);
   endtask

   // Wait until all requests went in and every result came back.
   task automatic drain();
      while (pending_tris.size() > 0 || req_valid || expected_tris.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   function automatic tpc_req_type rand_tri(int mode);
      tpc_req_type t;
      t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode)};
      if ($urandom_range(0, 9) == 0) t.v1_z = rand_coord(2);
      return t;
   endfunction

   task automatic add_tri(logic signed [COORD_W-1:0] z0, logic signed [COORD_W-1:0] z1,
         logic signed [COORD_W-1:0] z2);
      tpc_req_type t;
      t = rand_tri(1);
      t.v0_z = z0; t.v1_z = z1; t.v2_z = z2;
      pending_tris.push_back(t);
   endtask

   localparam logic signed [COORD_W-1:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] MINV = 32'sh8000_0000;

   initial begin
      int batch;
      errors = 0; accepted = 0; produced = 0;
      clipped_one = 0; clipped_two = 0; passed_whole = 0; culled = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      plane_pt[0] = 0; plane_pt[1] = 0; plane_pt[2] = POINT_Z_RESET;
      plane_nrm[0] = 0; plane_nrm[1] = 0; plane_nrm[2] = NORMAL_Z_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset plane, every inside/outside pattern, extremes, vertex on plane.
      add_tri(100000, 200000, 300000);
      add_tri(-100000, -200000, 0);
      add_tri(100000, -100000, -100000);
      add_tri(-100000, 100000, -100000);
      add_tri(-100000, -100000, 100000);
      add_tri(100000, 100000, -100000);
      add_tri(100000, -100000, 100000);
      add_tri(-100000, 100000, 100000);
      add_tri(6554, -100000, 6554);
      add_tri(MAXV, MINV, MINV);
      add_tri(MAXV, MAXV, MINV);
      add_tri(MINV, MINV, MINV);
      begin
         tpc_req_type t;
         t = {MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, 32'sd0};
         pending_tris.push_back(t);
         t = '1;
         pending_tris.push_back(t);
      end
      drain();

      // Zero normal culls everything.
      set_plane(0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) pending_tris.push_back(rand_tri(i % 3));
      drain();

      // Extreme planes and random planes in phases.
      set_plane(MAXV, MINV, MAXV, MINV, MAXV, MINV);
      for (int i = 0; i < 6; i++) pending_tris.push_back(rand_tri(i % 3));
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 2 == 0)
            set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
         else
            set_plane(rand_coord(1), rand_coord(1), rand_coord(1),
                      rand_coord(1), rand_coord(1), rand_coord(1));
         batch = TOTAL_RANDOM / 8;
         for (int i = 0; i < batch; i++) begin
            int m;
            m = $urandom_range(0, 9);
            pending_tris.push_back(rand_tri(m < 4 ? 0 : (m < 9 ? 1 : 2)));
         end
         drain();
      end

      $display("Covered %0d requests, %0d results: %0d whole, %0d one-in,",
               accepted, produced, passed_whole, clipped_one);
      $display("%0d two-in, %0d culled; planes at reset, zero, extreme and random",
               clipped_two, culled);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/tpc_pkg.sv
sv/tpc_divider.sv
sv/triangle_plane_clipper.sv
sv/tpc_checker.sv
bench/tb.sv
